@@ hdl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared types and constants: token and result formats, status codes,
// character codes, divider and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

	localparam int DATA_W     = 32;
	localparam int TOKQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;
	localparam int DIV_STEPS  = 32;
	localparam int DIV_CW     = $clog2(DIV_STEPS + 1);

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		TK_SKIP  = 2'd0,
		TK_DIGIT = 2'd1,
		TK_OP    = 2'd2,
		TK_BAD   = 2'd3
	} tok_kind_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FEW      = 3'd1,
		ST_BAD      = 3'd2,
		ST_NOT_ONE  = 3'd3,
		ST_DIV_ZERO = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		tok_kind_t  kind;
		op_t        op;
		logic [3:0] digit;
		logic       last;
	} token_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates a reverse-Polish integer expression arriving one character per
// transaction and returns one value and status per expression.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  input    | push / full           | char_code[7:0], last_char
//  result   | pop / empty           | result_value[31:0] signed, status[2:0]
//
// The front takes one character a cycle into a 4-entry token queue while it is not full.
// The back handles a space, digit or bad character in its idle state; + - *
// fetch into an execute state, / then a 32-step restoring divider and finish.
// Stack memory is not cleared by reset; no entry is read before written.
// The back holds a token while the 2-entry result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [7:0]         char_code,
	input  wire logic               last_char,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      result_value,
	output logic [2:0]              status
);

	localparam int TOK_W = $bits(rpn_pkg::token_t);
	localparam int RES_W = $bits(rpn_pkg::res_t);

	rpn_pkg::token_t  tok_in, tok_out;
	logic [TOK_W-1:0] tq_rdata;
	logic             tq_empty, tq_pop;
	rpn_pkg::res_t    res_in, res_out;
	logic [RES_W-1:0] rq_rdata;
	logic             rq_full, rq_push;

	rpn_front u_front (
		.char_code (char_code),
		.last_char (last_char),
		.tok       (tok_in)
	);

	rpn_queue #(
		.WIDTH (TOK_W),
		.DEPTH (rpn_pkg::TOKQ_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (tok_in),
		.full   (full),
		.pop    (tq_pop),
		.rdata  (tq_rdata),
		.empty  (tq_empty)
	);

	assign tok_out = rpn_pkg::token_t'(tq_rdata);

	rpn_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tq_empty),
		.tok       (tok_out),
		.tok_pop   (tq_pop),
		.out_full  (rq_full),
		.out_push  (rq_push),
		.out_data  (res_in)
	);

	rpn_queue #(
		.WIDTH (RES_W),
		.DEPTH (rpn_pkg::RESQ_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (res_in),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign res_out      = rpn_pkg::res_t'(rq_rdata);
	assign result_value = res_out.value;
	assign status       = res_out.status;

endmodule

`default_nettype wire

@@ hdl/rpn_queue.sv @@
// ----------------------------------------------------------------------------
// RPN small queue
// Register-based FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_queue #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rp_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wp_q] <= wdata;
	end

endmodule

`default_nettype wire

@@ hdl/rpn_front.sv @@
// ----------------------------------------------------------------------------
// RPN front end
// Classifies each incoming character into a token for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_front (
	input  wire logic [7:0]      char_code,
	input  wire logic            last_char,
	output rpn_pkg::token_t      tok
);

	// decode character class and operator
	always_comb begin
		tok.kind  = rpn_pkg::TK_BAD;
		tok.op    = rpn_pkg::OP_ADD;
		// low nibble of an ASCII digit is its value
		tok.digit = char_code[3:0];
		tok.last  = last_char;
		if (char_code == rpn_pkg::CH_SPACE) begin
			tok.kind = rpn_pkg::TK_SKIP;
		end else if (char_code >= rpn_pkg::CH_ZERO && char_code <= rpn_pkg::CH_NINE) begin
			tok.kind = rpn_pkg::TK_DIGIT;
		end else begin
			case (char_code)
				rpn_pkg::CH_PLUS: begin
					tok.kind = rpn_pkg::TK_OP;
					tok.op   = rpn_pkg::OP_ADD;
				end
				rpn_pkg::CH_MINUS: begin
					tok.kind = rpn_pkg::TK_OP;
					tok.op   = rpn_pkg::OP_SUB;
				end
				rpn_pkg::CH_STAR: begin
					tok.kind = rpn_pkg::TK_OP;
					tok.op   = rpn_pkg::OP_MUL;
				end
				rpn_pkg::CH_SLASH: begin
					tok.kind = rpn_pkg::TK_OP;
					tok.op   = rpn_pkg::OP_DIV;
				end
				default: begin
					tok.kind = rpn_pkg::TK_BAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/rpn_div.sv @@
// ----------------------------------------------------------------------------
// RPN divider
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rpn_pkg::div_req_t req,
	output rpn_pkg::div_rsp_t      rsp
);

	logic                       busy_q, done_q;
	logic [rpn_pkg::DIV_CW-1:0] step_q;
	logic [31:0]                rem_q, quo_q, dsr_q;
	logic [32:0]                rem_sh, diff;
	logic                       ge;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = !diff[32];

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= rpn_pkg::DIV_CW'(rpn_pkg::DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - rpn_pkg::DIV_CW'(1);
				if (step_q == rpn_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

@@ hdl/rpn_back.sv @@
// ----------------------------------------------------------------------------
// RPN back end
// Executes tokens against the value stack (top in a register, the rest in
// memory), keeps the sticky error and emits the result on the last token.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_back #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tok_empty,
	input  wire rpn_pkg::token_t tok,
	output logic                 tok_pop,
	input  wire logic            out_full,
	output logic                 out_push,
	output rpn_pkg::res_t        out_data
);

	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DIV  = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       cnt_q, cnt_d, cnt_m1, cnt_m2;
	rpn_pkg::status_t    err_q, err_d, st;
	logic [31:0]         tos_q, tos_d, nos_q, prod, quo;
	rpn_pkg::op_t        op_q;
	logic                last_q, neg_q;
	logic                fin, fin_last, wr_en, rd_en;
	logic [31:0]         mem [STACK_DEPTH];
	rpn_pkg::div_req_t   div_req;
	rpn_pkg::div_rsp_t   div_rsp;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign prod   = nos_q * tos_q;
	assign quo    = neg_q ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next-state and stack update
	always_comb begin
		state_d          = state_q;
		cnt_d            = cnt_q;
		err_d            = err_q;
		tos_d            = tos_q;
		tok_pop          = 1'b0;
		fin              = 1'b0;
		fin_last         = 1'b0;
		wr_en            = 1'b0;
		rd_en            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = nos_q[31] ? (32'd0 - nos_q) : nos_q;
		div_req.divisor  = tos_q[31] ? (32'd0 - tos_q) : tos_q;
		case (state_q)
			S_IDLE: begin
				// take a token only when a result has room to land
				if (!tok_empty && !out_full) begin
					tok_pop  = 1'b1;
					fin      = 1'b1;
					fin_last = tok.last;
					if (err_q == rpn_pkg::ST_OK) begin
						case (tok.kind)
							rpn_pkg::TK_DIGIT: begin
								if (cnt_q == CW'(STACK_DEPTH)) begin
									err_d = rpn_pkg::ST_OVERFLOW;
								end else begin
									wr_en = (cnt_q != '0);
									tos_d = 32'(tok.digit);
									cnt_d = cnt_q + CW'(1);
								end
							end
							rpn_pkg::TK_OP: begin
								if (cnt_q < CW'(2)) begin
									err_d = rpn_pkg::ST_FEW;
								end else if (tok.op == rpn_pkg::OP_DIV && tos_q == '0) begin
									err_d = rpn_pkg::ST_DIV_ZERO;
								end else begin
									fin     = 1'b0;
									rd_en   = 1'b1;
									state_d = S_EXEC;
								end
							end
							rpn_pkg::TK_BAD: begin
								err_d = rpn_pkg::ST_BAD;
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_EXEC: begin
				fin_last = last_q;
				fin      = 1'b1;
				cnt_d    = cnt_m1;
				state_d  = S_IDLE;
				case (op_q)
					rpn_pkg::OP_ADD: tos_d = nos_q + tos_q;
					rpn_pkg::OP_SUB: tos_d = nos_q - tos_q;
					rpn_pkg::OP_MUL: tos_d = prod;
					default: begin
						fin           = 1'b0;
						cnt_d         = cnt_q;
						div_req.start = 1'b1;
						state_d       = S_DIV;
					end
				endcase
			end
			S_DIV: begin
				fin_last = last_q;
				if (div_rsp.done) begin
					fin     = 1'b1;
					tos_d   = quo;
					cnt_d   = cnt_m1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// build the result, then clear for the next expression
		out_push = fin && fin_last;
		if (err_d != rpn_pkg::ST_OK)
			st = err_d;
		else if (cnt_d != CW'(1))
			st = rpn_pkg::ST_NOT_ONE;
		else
			st = rpn_pkg::ST_OK;
		out_data.status = st;
		out_data.value  = (st == rpn_pkg::ST_OK) ? $signed(tos_d) : '0;
		if (out_push) begin
			cnt_d = '0;
			err_d = rpn_pkg::ST_OK;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			err_q   <= rpn_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
		end
	end

	// operand and operation registers
	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (rd_en) begin
			op_q   <= tok.op;
			last_q <= tok.last;
		end
		if (div_req.start)
			neg_q <= nos_q[31] ^ tos_q[31];
	end

	// stack body below the top: spill on push, fetch second operand
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[cnt_m1[IW-1:0]] <= tos_q;
		if (rd_en)
			nos_q <= mem[cnt_m2[IW-1:0]];
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into full queue");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> (cnt_q == '0 && err_q == rpn_pkg::ST_OK))
		else $error("stack or error not cleared after result");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on an idle divider");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

endmodule

`default_nettype wire

@@ sim/rpn_eval_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN evaluator checker
// Watches the character and result channels of the evaluator, keeps its own
// copy of the value stack to predict each expression's value and status, and
// compares every popped result against the oldest prediction.
// ----------------------------------------------------------------------------

module rpn_eval_checker #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [31:0] result_value,
	input  logic [2:0]         status,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic signed [31:0] value;
		rpn_pkg::status_t   code;
	} expr_result_t;

	// shadow evaluator state
	logic [31:0]      eval_stack [STACK_DEPTH];
	int               eval_depth;
	rpn_pkg::status_t eval_error;
	expr_result_t     expected_results [$];

	initial mismatches = 0;

	// signed division truncated toward zero, done on magnitudes
	function automatic logic [31:0] div_toward_zero(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] q;
		mag_a = a[31] ? 32'd0 - a : a;
		mag_b = b[31] ? 32'd0 - b : b;
		q = mag_a / mag_b;
		return (a[31] ^ b[31]) ? 32'd0 - q : q;
	endfunction

	// advance the shadow stack by one character, queue a result on the last one
	task automatic eval_char(input logic [7:0] c, input logic is_last);
		logic [31:0]  lhs;
		logic [31:0]  rhs;
		logic [31:0]  r;
		logic         do_pop;
		expr_result_t res;
		if (eval_error == rpn_pkg::ST_OK) begin
			if (c == rpn_pkg::CH_SPACE) begin
				// skip
			end else if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) begin
				if (eval_depth >= STACK_DEPTH) begin
					eval_error = rpn_pkg::ST_OVERFLOW;
				end else begin
					eval_stack[eval_depth] = {28'd0, c[3:0]};
					eval_depth++;
				end
			end else if (c == rpn_pkg::CH_PLUS || c == rpn_pkg::CH_MINUS ||
				c == rpn_pkg::CH_STAR || c == rpn_pkg::CH_SLASH) begin
				if (eval_depth < 2) begin
					eval_error = rpn_pkg::ST_FEW;
				end else begin
					rhs = eval_stack[eval_depth - 1];
					lhs = eval_stack[eval_depth - 2];
					do_pop = 1'b1;
					r = '0;
					case (c)
						rpn_pkg::CH_PLUS:  r = lhs + rhs;
						rpn_pkg::CH_MINUS: r = lhs - rhs;
						rpn_pkg::CH_STAR:  r = lhs * rhs;
						default: begin
							if (rhs == 32'd0) begin
								eval_error = rpn_pkg::ST_DIV_ZERO;
								do_pop = 1'b0;
							end else begin
								r = div_toward_zero(lhs, rhs);
							end
						end
					endcase
					if (do_pop) begin
						eval_depth--;
						eval_stack[eval_depth - 1] = r;
					end
				end
			end else begin
				eval_error = rpn_pkg::ST_BAD;
			end
		end
		if (is_last) begin
			res.code = eval_error;
			if (res.code == rpn_pkg::ST_OK && eval_depth != 1)
				res.code = rpn_pkg::ST_NOT_ONE;
			res.value = (res.code == rpn_pkg::ST_OK) ? eval_stack[0] : 32'sd0;
			expected_results.push_back(res);
			eval_depth = 0;
			eval_error = rpn_pkg::ST_OK;
		end
	endtask

	// compare popped results first, then take in the accepted character
	always @(posedge clk or negedge arst_n) begin
		expr_result_t want;
		if (!arst_n) begin
			eval_depth = 0;
			eval_error = rpn_pkg::ST_OK;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transaction, value %0d status %0d",
						$time, result_value, status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.value) begin
						$display("%0t: result_value expected %0d, got %0d",
							$time, want.value, result_value);
						mismatches++;
					end
					if (status !== want.code) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.code, status);
						mismatches++;
					end
				end
			end
			if (push && !full)
				eval_char(char_code, last_char);
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ sim/tb_rpn_stack_evaluator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Feeds directed and random reverse-Polish expressions one character per
// transaction, with random idling on both sides, a long result hold-off and
// a full drain pause; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_rpn_stack_evaluator;

	localparam int STACK_DEPTH  = 32;
	localparam int N_ITEMS      = 1800;
	localparam int IDLE_PCT     = 14;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [7:0] OP_CHARS [4] = '{rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
		rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic [7:0]         char_code = 8'd0;
	logic               last_char = 1'b0;
	logic               pop = 1'b0;
	logic               full;
	logic               empty;
	logic signed [31:0] result_value;
	logic [2:0]         status;

	int   mismatches;
	int   outstanding;
	int   chars_sent = 0;
	int   cycle_count = 0;
	logic quiet = 1'b0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	logic [7:0] expr_q [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rpn_stack_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.last_char    (last_char),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.status       (status)
	);

	rpn_eval_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.last_char    (last_char),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rpn_stack_evaluator NOT OK");
			$finish;
		end
	end

	// result side: random pops, with a long hold-off on each request toggle
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// offer one character and wait until it is taken
	task automatic send_char(input logic [7:0] c, input logic is_last);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		char_code <= c;
		last_char <= is_last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_expr_q();
		foreach (expr_q[i])
			send_char(expr_q[i], i == expr_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		expr_q.delete();
		for (int i = 0; i < s.len(); i++)
			expr_q.push_back(s[i]);
		send_expr_q();
	endtask

	// drop push and hold until every predicted result has been popped
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_op(input int mul_pct);
		if ($urandom_range(99) < mul_pct)
			return rpn_pkg::CH_STAR;
		return OP_CHARS[$urandom_range(3)];
	endfunction

	// append a well-formed expression with n_ops operators
	task automatic add_formula(input int n_ops, input int mul_pct, input bit stack_first);
		int pushes_left;
		int ops_left;
		int depth;
		pushes_left = n_ops + 1;
		ops_left = n_ops;
		depth = 0;
		while (pushes_left + ops_left > 0) begin
			if ($urandom_range(99) < 10)
				expr_q.push_back(rpn_pkg::CH_SPACE);
			if (depth >= 2 && ops_left > 0 &&
				(pushes_left == 0 || (!stack_first && $urandom_range(1) == 1))) begin
				expr_q.push_back(pick_op(mul_pct));
				ops_left--;
				depth--;
			end else begin
				expr_q.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(9)));
				pushes_left--;
				depth++;
			end
		end
	endtask

	// break an expression: stray byte, lost character or extra operator
	task automatic mutate_expr();
		int pos;
		pos = $urandom_range(expr_q.size() - 1);
		case ($urandom_range(2))
			0: expr_q.insert(pos, 8'($urandom_range(255)));
			1: if (expr_q.size() > 1) expr_q.delete(pos);
			default: expr_q.insert(pos, pick_op(0));
		endcase
	endtask

	initial begin
		string s;
		int    expr_idx;
		int    mode;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single digits, each operator, every error path
		send_text("9");
		send_text("0");
		send_text("3 4+");
		send_text("27-");
		send_text("97*");
		send_text("07-2/");
		send_text("70/");
		send_text("5+");
		send_text("1+2");
		send_text("1x");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_text(" ");
		send_text("12");
		wait_drained();
		// most negative value divided by minus one
		s = "02";
		repeat (10) s = {s, "8*"};
		send_text({s, "-01-/"});
		// one digit more than the stack holds, then an ignored operator
		s = "";
		repeat (STACK_DEPTH + 1) s = {s, "9"};
		send_text({s, "+"});

		// random expressions
		expr_idx = 0;
		while (chars_sent < N_ITEMS) begin
			expr_idx++;
			if (expr_idx == 30)
				hold_toggle <= ~hold_toggle;
			if (expr_idx == 70)
				wait_drained();
			quiet <= (expr_idx >= 100 && expr_idx < 160);
			expr_q.delete();
			mode = $urandom_range(99);
			if (mode < 68) begin
				add_formula($urandom_range($urandom_range(1) ? 6 : 15), 25, 1'b0);
			end else if (mode < 78) begin
				add_formula($urandom_range(STACK_DEPTH + 1, STACK_DEPTH - 1), 70, 1'b1);
			end else if (mode < 90) begin
				add_formula($urandom_range(8, 1), 25, 1'b0);
				mutate_expr();
			end else begin
				repeat ($urandom_range(6, 1))
					expr_q.push_back(8'($urandom_range(255)));
			end
			send_expr_q();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_rpn_stack_evaluator OK");
		else
			$display("tb_rpn_stack_evaluator NOT OK");
		$finish;
	end

endmodule
